// File: hdl/pixelwise_image_arithmetic_assert.svh
// Assertion helpers; expect clk and rst in the scope of use
`ifndef PIXELWISE_IMAGE_ARITHMETIC_ASSERT_SVH
`define PIXELWISE_IMAGE_ARITHMETIC_ASSERT_SVH

// same-cycle implication
`define PIA_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pixel alu check failed");

// next-cycle implication
`define PIA_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pixel alu check failed");

`endif

// File: hdl/pia_pkg.sv
package pia_pkg;

  // operation codes; 12 to 15 mean nothing and give zero
  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_GE,
    OP_LE, OP_GT, OP_LT, OP_AND, OP_OR, OP_NOT
  } op_t;

  // register indexes
  localparam logic [2:0] REG_OPERATION = 3'd0;
  localparam logic [2:0] REG_A_SOURCE  = 3'd1;
  localparam logic [2:0] REG_B_SOURCE  = 3'd2;
  localparam logic [2:0] REG_SCALAR_A  = 3'd3;
  localparam logic [2:0] REG_SCALAR_B  = 3'd4;

  typedef struct packed {
    logic [3:0] operation;
    logic       a_source;
    logic       b_source;
  } cfg_t;

endpackage

// File: hdl/pia_in_if.sv
interface pia_in_if #(parameter int PIXEL_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_a;
  logic [PIXEL_BITS-1:0] pixel_b;

  modport source (output valid, pixel_a, pixel_b, input ready);
  modport sink (input valid, pixel_a, pixel_b, output ready);
endinterface

// File: hdl/pia_out_if.sv
interface pia_out_if #(parameter int PIXEL_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] result_pixel;
  logic                  saturated;

  modport source (output valid, result_pixel, saturated, input ready);
  modport sink (input valid, result_pixel, saturated, output ready);
endinterface

// File: hdl/pia_cfg.sv
module pia_cfg import pia_pkg::*; #(
  parameter int P  = 32,
  parameter int DW = 32,
  parameter int AW = 5,
  parameter int SH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [DW-1:0] pwdata,
  output logic [DW-1:0] prdata,
  output logic          pready,
  output cfg_t          cfg,
  output logic [P-1:0]  scalar_a,
  output logic [P-1:0]  scalar_b
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[AW-1:SH];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg      <= '0;
      scalar_a <= '0;
      scalar_b <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_OPERATION: cfg.operation <= pwdata[3:0];
        REG_A_SOURCE:  cfg.a_source  <= pwdata[0];
        REG_B_SOURCE:  cfg.b_source  <= pwdata[0];
        REG_SCALAR_A:  scalar_a      <= pwdata[P-1:0];
        REG_SCALAR_B:  scalar_b      <= pwdata[P-1:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    unique case (idx)
      REG_OPERATION: prdata = DW'(cfg.operation);
      REG_A_SOURCE:  prdata = DW'(cfg.a_source);
      REG_B_SOURCE:  prdata = DW'(cfg.b_source);
      REG_SCALAR_A:  prdata = DW'(scalar_a);
      REG_SCALAR_B:  prdata = DW'(scalar_b);
      default:       prdata = '0;
    endcase
  end

endmodule

// File: hdl/pia_div.sv
// Restoring divider, one quotient bit per pipeline stage
module pia_div import pia_pkg::*; #(
  parameter int P  = 32,
  parameter int W  = 48,
  parameter int SW = 39
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [W-1:0]  dvd,
  input  logic [P-1:0]  dvs,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [W-1:0]  quo,
  output logic [SW-1:0] side_out
);

  logic          vld [W];
  logic [P-1:0]  rem [W];
  logic [W-1:0]  qd  [W];
  logic [P-1:0]  dv  [W];
  logic [SW-1:0] sd  [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic          v_i;
    logic [P-1:0]  rem_i;
    logic [W-1:0]  qd_i;
    logic [P-1:0]  dv_i;
    logic [SW-1:0] sd_i;
    logic [P:0]    t;
    logic [P:0]    diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_i   = in_valid;
      assign rem_i = '0;
      assign qd_i  = dvd;
      assign dv_i  = dvs;
      assign sd_i  = side_in;
    end else begin : g_next
      assign v_i   = vld[k-1];
      assign rem_i = rem[k-1];
      assign qd_i  = qd[k-1];
      assign dv_i  = dv[k-1];
      assign sd_i  = sd[k-1];
    end

    // shift in next dividend bit, trial subtract
    assign t    = {rem_i, qd_i[W-1]};
    assign diff = t - {1'b0, dv_i};
    assign ge   = t >= {1'b0, dv_i};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k] <= ge ? diff[P-1:0] : t[P-1:0];
        qd[k]  <= {qd_i[W-2:0], ge};
        dv[k]  <= dv_i;
        sd[k]  <= sd_i;
      end
    end
  end

  assign out_valid = vld[W-1];
  assign quo       = qd[W-1];
  assign side_out  = sd[W-1];

endmodule

// File: hdl/pixelwise_image_arithmetic.sv
// Pixelwise fixed point ALU, one word accepted per cycle when not stalled.
// Path, shared by all operations (Q16.16 by default): operand select, stage 2,
// stage 3, the divider, which resolves one quotient bit per stage, and the output register.
// Throughput: one word per cycle; a stall at the output freezes every stage.
// Reset (rst, synchronous): clears all valid bits and the configuration registers to zero.
module pixelwise_image_arithmetic import pia_pkg::*; #(
  parameter int PIXEL_BITS = 32,
  parameter int FRAC_BITS  = 16,
  localparam int DW = (PIXEL_BITS > 32) ? 64 : 32,
  localparam int SH = (PIXEL_BITS > 32) ? 3 : 2,
  localparam int AW = SH + 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [DW-1:0] pwdata,
  output logic [DW-1:0] prdata,
  output logic          pready,
  pia_in_if.sink        in_ch,
  pia_out_if.source     out_ch
);

  localparam int P  = PIXEL_BITS;
  localparam int F  = FRAC_BITS;
  localparam int W  = P + F;
  localparam int SW = P + 7;
  localparam logic [P-1:0] ONE  = {{(P-1){1'b0}}, 1'b1} << F;
  localparam logic [P-1:0] MAXP = {1'b0, {(P-1){1'b1}}};
  localparam logic [P-1:0] MINP = {1'b1, {(P-1){1'b0}}};

  cfg_t         cfg;
  logic [P-1:0] scalar_a;
  logic [P-1:0] scalar_b;
  logic         adv;

  pia_cfg #(.P(P), .DW(DW), .AW(AW), .SH(SH)) u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg, .scalar_a, .scalar_b
  );

  // whole pipeline moves when the output slot is free or being taken
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: operand select
  logic         v1;
  logic [3:0]   op1;
  logic [P-1:0] a1, b1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1 <= cfg.operation;
      a1  <= cfg.a_source ? scalar_a : in_ch.pixel_a;
      b1  <= cfg.b_source ? scalar_b : in_ch.pixel_b;
    end
  end

  // stage 2: add/sub, compares, logic, magnitudes
  logic [P-1:0] sum, dif, val_c, ma_c, mb_c;
  logic         add_ovf, sub_ovf, sat_c;

  assign sum     = a1 + b1;
  assign dif     = a1 - b1;
  assign add_ovf = (a1[P-1] == b1[P-1]) && (sum[P-1] != a1[P-1]);
  assign sub_ovf = (a1[P-1] != b1[P-1]) && (dif[P-1] != a1[P-1]);
  assign ma_c    = a1[P-1] ? (~a1 + 1'b1) : a1;
  assign mb_c    = b1[P-1] ? (~b1 + 1'b1) : b1;

  always_comb begin
    sat_c = 1'b0;
    case (op_t'(op1))
      OP_ADD: begin
        sat_c = add_ovf;
        val_c = add_ovf ? (a1[P-1] ? MINP : MAXP) : sum;
      end
      OP_SUB: begin
        sat_c = sub_ovf;
        val_c = sub_ovf ? (a1[P-1] ? MINP : MAXP) : dif;
      end
      OP_EQ:  val_c = (a1 == b1) ? ONE : '0;
      OP_GE:  val_c = ($signed(a1) >= $signed(b1)) ? ONE : '0;
      OP_LE:  val_c = ($signed(a1) <= $signed(b1)) ? ONE : '0;
      OP_GT:  val_c = ($signed(a1) > $signed(b1)) ? ONE : '0;
      OP_LT:  val_c = ($signed(a1) < $signed(b1)) ? ONE : '0;
      OP_AND: val_c = ((a1 != '0) && (b1 != '0)) ? ONE : '0;
      OP_OR:  val_c = ((a1 != '0) || (b1 != '0)) ? ONE : '0;
      OP_NOT: val_c = (a1 == '0) ? ONE : '0;
      default: val_c = '0;
    endcase
  end

  logic         v2, sat2, neg2;
  logic [3:0]   op2;
  logic [P-1:0] val2, ma2, mb2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op2  <= op1;
      val2 <= val_c;
      sat2 <= sat_c;
      neg2 <= a1[P-1] ^ b1[P-1];
      ma2  <= ma_c;
      mb2  <= mb_c;
    end
  end

  // stage 3: magnitude product
  logic           v3, sat3, neg3;
  logic [3:0]     op3;
  logic [P-1:0]   val3, ma3, mb3;
  logic [2*P-1:0] prod3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op3   <= op2;
      val3  <= val2;
      sat3  <= sat2;
      neg3  <= neg2;
      ma3   <= ma2;
      mb3   <= mb2;
      prod3 <= (2*P)'(ma2) * (2*P)'(mb2);
    end
  end

  // product scaling and clamp, ahead of the divider
  logic [2*P-1:0] pmag, plim;
  logic           msat, sat_s;
  logic [P-1:0]   val_s;
  logic [SW-1:0]  side_in, side_out;
  logic [W-1:0]   dvd, quo;
  logic           vd;

  assign pmag  = prod3 >> F;
  assign plim  = neg3 ? (2*P)'(MINP) : (2*P)'(MAXP);
  assign msat  = pmag > plim;
  assign val_s = (op_t'(op3) == OP_MUL) ? (msat ? plim[P-1:0] : pmag[P-1:0]) : val3;
  assign sat_s = (op_t'(op3) == OP_MUL) ? msat : sat3;
  assign side_in = {op3, neg3, (mb3 == '0), sat_s, val_s};
  assign dvd     = W'(ma3) << F;

  pia_div #(.P(P), .W(W), .SW(SW)) u_div (
    .clk, .rst, .adv, .in_valid(v3), .dvd, .dvs(mb3), .side_in,
    .out_valid(vd), .quo, .side_out
  );

  // final sign and clamp
  logic [3:0]   op_f;
  logic         neg_f, dz_f, sat_f, dsat, sat_o;
  logic [P-1:0] val_f, dmag, res_o;
  logic [W-1:0] dlim;

  assign {op_f, neg_f, dz_f, sat_f, val_f} = side_out;
  assign dlim = neg_f ? W'(MINP) : W'(MAXP);
  assign dsat = quo > dlim;
  assign dmag = dsat ? dlim[P-1:0] : quo[P-1:0];

  always_comb begin
    case (op_t'(op_f))
      OP_MUL: begin
        res_o = neg_f ? (~val_f + 1'b1) : val_f;
        sat_o = sat_f;
      end
      OP_DIV: begin
        res_o = dz_f ? '0 : (neg_f ? (~dmag + 1'b1) : dmag);
        sat_o = !dz_f && dsat;
      end
      default: begin
        res_o = val_f;
        sat_o = sat_f;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (adv) out_ch.valid <= vd;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.result_pixel <= res_o;
      out_ch.saturated    <= sat_o;
    end
  end

`include "pixelwise_image_arithmetic_assert.svh"

  `PIA_CHECK(a_sat_extreme, out_ch.valid && out_ch.saturated, (out_ch.result_pixel == MAXP) || (out_ch.result_pixel == MINP))
  `PIA_CHECK(a_logic_bool, out_ch.valid && (cfg.operation >= OP_EQ) && (cfg.operation <= OP_NOT), !out_ch.saturated && ((out_ch.result_pixel == ONE) || (out_ch.result_pixel == '0)))
  `PIA_CHECK_NEXT(a_stage_move, v1 && adv, v2)
  `PIA_CHECK_NEXT(a_stall_hold, !adv, $stable(v3) && $stable(prod3))

endmodule

// File: dv/tb_pixelwise_image_arithmetic.sv
module tb_pixelwise_image_arithmetic import pia_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 52;
  localparam int N_RANDOM = 1430;
  localparam int WATCHDOG = 20000;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] PMAX = 32'h7fff_ffff;
  localparam logic [31:0] PMIN = 32'h8000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pia_in_if #(32) in_ch ();
  pia_out_if #(32) out_ch ();

  pixelwise_image_arithmetic dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct packed {
    logic [31:0] pixel;
    logic        sat;
  } pixel_result_t;

  // shadow of the register file
  logic [3:0]  op_reg;
  logic        a_sel, b_sel;
  logic [31:0] sc_a, sc_b;

  pixel_result_t expected_pixels[$];
  int mismatches = 0;
  int words_out = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  bit drain_hold = 1'b0;
  int n_sat = 0;

  // append one expectation at the tail of the queue
  task automatic log_expected(pixel_result_t r);
    expected_pixels.insert(expected_pixels.size(), r);
  endtask

  // clamp a signed magnitude to the pixel range
  function automatic pixel_result_t clamp_signed(bit neg, logic [127:0] mag);
    pixel_result_t r;
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    r.sat = 1'b0;
    if (mag > lim) begin
      mag = lim;
      r.sat = 1'b1;
    end
    r.pixel = neg ? 32'(-mag[31:0]) : mag[31:0];
    return r;
  endfunction

  function automatic pixel_result_t compute_pixel(logic [31:0] pa, logic [31:0] pb);
    pixel_result_t r;
    logic [31:0] a, b, t;
    logic [127:0] ma, mb, prod;
    bit neg;
    a = a_sel ? sc_a : pa;
    b = b_sel ? sc_b : pb;
    ma = a[31] ? 128'(-a) & 128'hffff_ffff : 128'(a);
    mb = b[31] ? 128'(-b) & 128'hffff_ffff : 128'(b);
    neg = a[31] ^ b[31];
    r = '0;
    case (op_reg)
      OP_ADD: begin
        t = a + b;
        if (a[31] == b[31] && t[31] != a[31]) begin
          r.sat = 1'b1;
          t = a[31] ? PMIN : PMAX;
        end
        r.pixel = t;
      end
      OP_SUB: begin
        t = a - b;
        if (a[31] != b[31] && t[31] != a[31]) begin
          r.sat = 1'b1;
          t = a[31] ? PMIN : PMAX;
        end
        r.pixel = t;
      end
      OP_MUL: begin
        prod = (ma * mb) >> 16;
        r = clamp_signed(neg, prod);
      end
      OP_DIV: if (mb != 0) r = clamp_signed(neg, (ma << 16) / mb);
      OP_EQ:  r.pixel = (a == b) ? ONE : '0;
      OP_GE:  r.pixel = ($signed(a) >= $signed(b)) ? ONE : '0;
      OP_LE:  r.pixel = ($signed(a) <= $signed(b)) ? ONE : '0;
      OP_GT:  r.pixel = ($signed(a) > $signed(b)) ? ONE : '0;
      OP_LT:  r.pixel = ($signed(a) < $signed(b)) ? ONE : '0;
      OP_AND: r.pixel = (a != 0 && b != 0) ? ONE : '0;
      OP_OR:  r.pixel = (a != 0 || b != 0) ? ONE : '0;
      OP_NOT: r.pixel = (a == 0) ? ONE : '0;
      default: r = '0;
    endcase
    return r;
  endfunction

  // APB write: setup then access
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_OPERATION: op_reg = val[3:0];
      REG_A_SOURCE:  a_sel = val[0];
      REG_B_SOURCE:  b_sel = val[0];
      REG_SCALAR_A:  sc_a = val;
      REG_SCALAR_B:  sc_b = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [3:0] op, logic as, logic bs, logic [31:0] sa,
                            logic [31:0] sb);
    reg_write(REG_OPERATION, {28'(0), op});
    reg_write(REG_A_SOURCE, {31'(0), as});
    reg_write(REG_B_SOURCE, {31'(0), bs});
    reg_write(REG_SCALAR_A, sa);
    reg_write(REG_SCALAR_B, sb);
  endtask

  // send one word; expected result is the typed one if given, else predicted
  // valid stays high after the handshake so a zero gap gives back to back words
  task automatic send_pixels(logic [31:0] pa, logic [31:0] pb, bit typed = 1'b0,
                             pixel_result_t want = '0);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel_a <= pa;
    in_ch.pixel_b <= pb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    log_expected(typed ? want : compute_pixel(pa, pb));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0 && !timed_out) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 4)) << 16;
      1: return $urandom_range(0, 1) ? PMAX : PMIN;
      2: return 32'($signed(16'($urandom)));
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // result sink with random stalls and one long hold-off
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (1) begin
      if (drain_hold) begin
        out_ch.ready <= 1'b0;
        repeat (200) @(negedge clk);
        drain_hold = 1'b0;
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      words_out++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_ch.result_pixel);
      end else begin
        want = expected_pixels.pop_front();
        if (want.sat) n_sat++;
        if (out_ch.result_pixel !== want.pixel || out_ch.saturated !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: pixel exp %h got %h, sat exp %b got %b",
                     want.pixel, out_ch.result_pixel, want.sat, out_ch.saturated);
        end
      end
    end
  end

  // watchdog on cycles without any accepted word or register access
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("[pixelwise_image_arithmetic] ERROR");
      $finish;
    end
  end

  typedef struct {
    logic [3:0]  op;
    logic        as, bs;
    logic [31:0] sa, sb, pa, pb;
    bit          typed;
    logic [31:0] res;
    logic        sat;
  } vector_t;

  vector_t vectors[] = '{
    '{OP_ADD, 0, 0, 0, 0, PMAX, 32'd1, 1, PMAX, 1},
    '{OP_ADD, 0, 0, 0, 0, PMIN, PMAX, 1, 32'hffff_ffff, 0},
    '{OP_ADD, 0, 0, 0, 0, PMIN, PMIN, 1, PMIN, 1},
    '{OP_SUB, 0, 0, 0, 0, PMIN, 32'd1, 1, PMIN, 1},
    '{OP_SUB, 0, 0, 0, 0, PMAX, PMIN, 1, PMAX, 1},
    '{OP_MUL, 0, 0, 0, 0, PMAX, PMAX, 1, PMAX, 1},
    '{OP_MUL, 0, 0, 0, 0, PMIN, PMAX, 1, PMIN, 1},
    '{OP_MUL, 0, 0, 0, 0, 32'hfffe_8000, 32'h0002_0000, 0, 0, 0},
    '{OP_DIV, 0, 0, 0, 0, PMAX, 32'd0, 1, 32'd0, 0},
    '{OP_DIV, 0, 0, 0, 0, PMIN, 32'd1, 1, PMIN, 1},
    '{OP_DIV, 0, 0, 0, 0, 32'hfff9_0000, 32'h0002_0000, 0, 0, 0},
    '{OP_DIV, 1, 1, 32'h0006_0000, 32'h0003_0000, 0, 0, 1, 32'h0002_0000, 0},
    '{OP_EQ, 0, 0, 0, 0, PMIN, PMIN, 1, ONE, 0},
    '{OP_GE, 0, 0, 0, 0, PMIN, PMAX, 1, 32'd0, 0},
    '{OP_LE, 0, 0, 0, 0, PMIN, PMAX, 1, ONE, 0},
    '{OP_GT, 0, 0, 0, 0, 32'd5, 32'd5, 1, 32'd0, 0},
    '{OP_LT, 0, 0, 0, 0, 32'hffff_ffff, 32'd0, 1, ONE, 0},
    '{OP_AND, 0, 0, 0, 0, 32'd1, 32'd0, 1, 32'd0, 0},
    '{OP_OR, 0, 0, 0, 0, 32'd0, PMIN, 1, ONE, 0},
    '{OP_NOT, 0, 0, 0, 0, 32'd0, 32'hffff_ffff, 1, ONE, 0},
    '{OP_NOT, 1, 0, 32'd7, 0, 32'd0, 32'd0, 1, 32'd0, 0},
    '{4'd12, 0, 0, 0, 0, PMAX, PMAX, 1, 32'd0, 0},
    '{4'd15, 1, 1, PMIN, PMIN, 0, 0, 1, 32'd0, 0},
    '{OP_SUB, 0, 1, 0, 32'h0001_8000, 32'h0003_0000, 0, 0, 0, 0}
  };

  initial begin
    int n_cfg;
    pixel_result_t want;
    in_ch.valid = 1'b0;
    in_ch.pixel_a = '0;
    in_ch.pixel_b = '0;
    op_reg = OP_ADD; a_sel = 0; b_sel = 0; sc_a = '0; sc_b = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: plain add of the two pixels
    send_pixels(32'h0001_0000, 32'h0002_0000, 1'b1, '{32'h0003_0000, 1'b0});

    // directed table, configuring per row
    foreach (vectors[i]) begin
      wait_drained();
      set_config(vectors[i].op, vectors[i].as, vectors[i].bs, vectors[i].sa, vectors[i].sb);
      want.pixel = vectors[i].res;
      want.sat = vectors[i].sat;
      send_pixels(vectors[i].pa, vectors[i].pb, vectors[i].typed, want);
    end

    // random phases, each under a fresh setting
    n_cfg = 0;
    for (int sent = 0; sent < N_RANDOM; ) begin
      int len;
      wait_drained();
      if (n_cfg == 3) drain_hold = 1'b1;
      set_config((n_cfg % 14 == 13) ? 4'($urandom_range(12, 15)) : 4'(n_cfg % 12),
                 ($urandom_range(0, 4) == 0), ($urandom_range(0, 4) == 0),
                 rand_pixel(), rand_pixel());
      len = $urandom_range(40, 80);
      if (n_cfg == 3) len = 150;
      for (int k = 0; k < len; k++) begin
        if ((k / 20) % 3 == 2) begin
          // burst with no sender gap
          in_ch.valid <= 1'b1;
          in_ch.pixel_a <= rand_pixel();
          in_ch.pixel_b <= rand_pixel();
          @(posedge clk);
          while (!in_ch.ready) @(posedge clk);
          log_expected(compute_pixel(in_ch.pixel_a, in_ch.pixel_b));
          @(negedge clk);
        end else begin
          send_pixels(rand_pixel(), rand_pixel());
        end
      end
      sent += len;
      n_cfg++;
    end

    wait_drained();
    $display("covered %0d config phases, %0d result words, %0d saturated",
             n_cfg + vectors.size(), words_out, n_sat);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("[pixelwise_image_arithmetic] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_pixels.size());
      $display("[pixelwise_image_arithmetic] ERROR");
    end
    $finish;
  end
endmodule
